FILE: rtl/grid_line_cell_walker_assert.svh
// Assertion macros for the grid line cell walker, empty in synthesis.
`ifndef GRID_LINE_CELL_WALKER_ASSERT_SVH
`define GRID_LINE_CELL_WALKER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on the rising clock edge, switched off while reset is held.
`define GLCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on the rising clock edge at all times, reset included.
`define GLCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GLCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define GLCW_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/glcw_pkg.sv
// Shared types for the grid line cell walker.
package glcw_pkg;

    // Request kind carried by the mode field.
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

endpackage

FILE: rtl/grid_line_cell_walker.sv
// Top level of the four-connected grid line cell walker.
//
//  Channel   Handshake                 Payload
//  input     i_in_valid / o_in_stall   i_mode, i_x_start, i_y_start, i_x_end, i_y_end
//  output    o_out_valid / i_out_stall o_cell_x, o_cell_y, o_last_cell
//
// One request is taken per cycle while o_in_stall is low; a step request's cell
// appears on the output in the cycle after it is accepted, from a single output register.
// The walk state advances in the same cycle that the step request is taken.
// The input stalls only while a cell waits in the output register and the
// output side stalls. Reset (synchronous, active low) clears the walk so that
// step requests give no cell until the first load request.
module grid_line_cell_walker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  glcw_pkg::t_mode               i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_x_start,
    input  logic signed [COORD_WIDTH-1:0] i_y_start,
    input  logic signed [COORD_WIDTH-1:0] i_x_end,
    input  logic signed [COORD_WIDTH-1:0] i_y_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_cell_x,
    output logic signed [COORD_WIDTH-1:0] o_cell_y,
    output logic                          o_last_cell
);
    import glcw_pkg::*;

`include "grid_line_cell_walker_assert.svh"

    localparam int CNT_W = COORD_WIDTH + 1;
    localparam int ERR_W = COORD_WIDTH + 2;
    localparam logic [COORD_WIDTH-1:0] COORD_ONE = COORD_WIDTH'(1);
    localparam logic [CNT_W-1:0]       CNT_ONE   = CNT_W'(1);

    // Walk state.
    logic signed [COORD_WIDTH-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_WIDTH-1:0] r_cur_y, n_cur_y;
    logic signed [ERR_W-1:0]       r_error, n_error;
    logic        [CNT_W-1:0]       r_remaining, n_remaining;
    logic        [CNT_W-1:0]       r_twice_dx, n_twice_dx;
    logic        [CNT_W-1:0]       r_twice_dy, n_twice_dy;
    logic                          r_x_neg, n_x_neg;
    logic                          r_y_neg, n_y_neg;

    // Output register.
    logic                          r_out_valid, n_out_valid;
    logic signed [COORD_WIDTH-1:0] r_out_x, n_out_x;
    logic signed [COORD_WIDTH-1:0] r_out_y, n_out_y;
    logic                          r_out_last, n_out_last;

    // Setup results for a load request.
    logic        [CNT_W-1:0]       w_ld_twice_dx;
    logic        [CNT_W-1:0]       w_ld_twice_dy;
    logic signed [ERR_W-1:0]       w_ld_error;
    logic        [CNT_W-1:0]       w_ld_count;
    logic                          w_ld_x_neg;
    logic                          w_ld_y_neg;

    logic                          w_in_acc;
    logic                          w_load;
    logic                          w_emit;
    logic                          w_move_x;
    logic        [CNT_W-1:0]       w_rem_dec;

    glcw_setup #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_setup (
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_twice_dx (w_ld_twice_dx),
        .o_twice_dy (w_ld_twice_dy),
        .o_error    (w_ld_error),
        .o_count    (w_ld_count),
        .o_x_neg    (w_ld_x_neg),
        .o_y_neg    (w_ld_y_neg)
    );

    // Handshake: hold off new requests only while a cell is stuck in the output register.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_load     = w_in_acc & (i_mode == MODE_LOAD);
    assign w_emit     = w_in_acc & (i_mode == MODE_STEP) & (r_remaining != '0);
    assign w_move_x   = r_error > $signed(ERR_W'(0));
    assign w_rem_dec  = r_remaining - CNT_ONE;

    // Next walk state: a load replaces the line, a step moves one cell.
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_error     = r_error;
        n_remaining = r_remaining;
        n_twice_dx  = r_twice_dx;
        n_twice_dy  = r_twice_dy;
        n_x_neg     = r_x_neg;
        n_y_neg     = r_y_neg;
        if (w_load) begin
            n_cur_x     = i_x_start;
            n_cur_y     = i_y_start;
            n_error     = w_ld_error;
            n_remaining = w_ld_count;
            n_twice_dx  = w_ld_twice_dx;
            n_twice_dy  = w_ld_twice_dy;
            n_x_neg     = w_ld_x_neg;
            n_y_neg     = w_ld_y_neg;
        end else if (w_emit) begin
            if (w_move_x) begin
                n_cur_x = r_x_neg ? r_cur_x - COORD_ONE : r_cur_x + COORD_ONE;
                n_error = r_error - $signed({1'b0, r_twice_dy});
            end else begin
                n_cur_y = r_y_neg ? r_cur_y - COORD_ONE : r_cur_y + COORD_ONE;
                n_error = r_error + $signed({1'b0, r_twice_dx});
            end
            n_remaining = w_rem_dec;
        end
    end

    // Next output register contents: load a new cell or let the taken one drain.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_x     = r_cur_x;
            n_out_y     = r_cur_y;
            n_out_last  = (r_remaining == CNT_ONE);
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur_x    <= n_cur_x;
        r_cur_y    <= n_cur_y;
        r_error    <= n_error;
        r_twice_dx <= n_twice_dx;
        r_twice_dy <= n_twice_dy;
        r_x_neg    <= n_x_neg;
        r_y_neg    <= n_y_neg;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_x    = r_out_x;
    assign o_cell_y    = r_out_y;
    assign o_last_cell = r_out_last;

    // A cell leaves the count by exactly one per emitted step.
    `GLCW_ASSERT(a_step_counts_down, i_clk, i_rst_n, w_emit |=> r_remaining == $past(w_rem_dec), "cell count did not drop by one on a step")
    // Every load leaves at least one cell to walk.
    `GLCW_ASSERT(a_load_has_cells, i_clk, i_rst_n, w_load |=> r_remaining != '0, "load left an empty walk")
    // A new output cell only follows an accepted step request.
    `GLCW_ASSERT(a_out_from_step, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_emit), "output cell without a step request")

endmodule

FILE: rtl/glcw_setup.sv
// Line setup: distances, directions, initial error and cell count from two endpoints.
module glcw_setup #(
    parameter int COORD_WIDTH = 16
) (
    input  logic signed [COORD_WIDTH-1:0] i_x_start,
    input  logic signed [COORD_WIDTH-1:0] i_y_start,
    input  logic signed [COORD_WIDTH-1:0] i_x_end,
    input  logic signed [COORD_WIDTH-1:0] i_y_end,
    output logic        [COORD_WIDTH:0]   o_twice_dx,
    output logic        [COORD_WIDTH:0]   o_twice_dy,
    output logic signed [COORD_WIDTH+1:0] o_error,
    output logic        [COORD_WIDTH:0]   o_count,
    output logic                          o_x_neg,
    output logic                          o_y_neg
);
    localparam int DIFF_W = COORD_WIDTH + 1;

    logic signed [DIFF_W-1:0]      w_diff_x;
    logic signed [DIFF_W-1:0]      w_diff_y;
    logic signed [DIFF_W-1:0]      w_abs_x;
    logic signed [DIFF_W-1:0]      w_abs_y;
    logic        [COORD_WIDTH-1:0] w_dx;
    logic        [COORD_WIDTH-1:0] w_dy;
    logic                          w_x_fwd;
    logic                          w_y_fwd;

    // Signed differences one bit wider than the coordinates, so they never overflow.
    assign w_diff_x = {i_x_end[COORD_WIDTH-1], i_x_end} - {i_x_start[COORD_WIDTH-1], i_x_start};
    assign w_diff_y = {i_y_end[COORD_WIDTH-1], i_y_end} - {i_y_start[COORD_WIDTH-1], i_y_start};

    // An axis walks forward only when the end lies strictly past the start.
    assign w_x_fwd = i_x_end > i_x_start;
    assign w_y_fwd = i_y_end > i_y_start;
    assign o_x_neg = ~w_x_fwd;
    assign o_y_neg = ~w_y_fwd;

    // Magnitudes always fit in the coordinate width as unsigned values.
    assign w_abs_x = w_x_fwd ? w_diff_x : -w_diff_x;
    assign w_abs_y = w_y_fwd ? w_diff_y : -w_diff_y;
    assign w_dx    = w_abs_x[COORD_WIDTH-1:0];
    assign w_dy    = w_abs_y[COORD_WIDTH-1:0];

    // Doubled deltas, starting error and total number of cells on the line.
    assign o_twice_dx = {w_dx, 1'b0};
    assign o_twice_dy = {w_dy, 1'b0};
    assign o_error    = $signed({2'b00, w_dx}) - $signed({2'b00, w_dy});
    assign o_count    = {1'b0, w_dx} + {1'b0, w_dy} + DIFF_W'(1);

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the four-connected grid line cell walker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import glcw_pkg::*;

    localparam int COORD_W     = 16;
    localparam int COORD_MAX   = 2 ** (COORD_W - 1) - 1;
    localparam int COORD_MIN   = -(2 ** (COORD_W - 1));
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    typedef logic signed [COORD_W-1:0] t_coord;

    // One cell of a walk as it should leave the block.
    typedef struct {
        t_coord x;
        t_coord y;
        logic   is_last;
    } t_cell;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    t_mode  i_mode      = MODE_STEP;
    t_coord i_x_start   = '0;
    t_coord i_y_start   = '0;
    t_coord i_x_end     = '0;
    t_coord i_y_end     = '0;
    logic   i_out_stall = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_coord o_cell_x;
    t_coord o_cell_y;
    logic   o_last_cell;

    // Walker state as the predictor tracks it.
    t_coord              pos_x      = '0;
    t_coord              pos_y      = '0;
    logic signed [18:0]  err_acc    = '0;
    logic        [17:0]  cells_left = '0;
    logic        [17:0]  twice_dx   = '0;
    logic        [17:0]  twice_dy   = '0;
    logic                x_neg      = 1'b0;
    logic                y_neg      = 1'b0;

    t_cell expected_cells[$];
    int    mismatch_count = 0;
    int    cycle_count    = 0;

    // Sender burst shaping and receiver stall shaping.
    int burst_left = 0;
    int gap_max    = 0;
    int stall_pct  = 0;
    int stall_run  = 0;
    bit stall_now  = 1'b0;

    grid_line_cell_walker #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cell_x   (o_cell_x),
        .o_cell_y   (o_cell_y),
        .o_last_cell(o_last_cell)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver stalls in runs of random length, at a density set per phase.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_run = $urandom_range(1, 6);
            stall_now = ($urandom_range(0, 99) < stall_pct);
        end
        stall_run--;
        i_out_stall <= stall_now;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Advance the walker model by one accepted request.
    task automatic predict_request(input t_mode m, input t_coord xs, input t_coord ys,
                                   input t_coord xe, input t_coord ye);
        int    dx;
        int    dy;
        t_cell c;
        if (m == MODE_LOAD) begin
            dx         = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
            dy         = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
            pos_x      = xs;
            pos_y      = ys;
            x_neg      = !(xe > xs);
            y_neg      = !(ye > ys);
            err_acc    = 19'(dx - dy);
            twice_dx   = 18'(2 * dx);
            twice_dy   = 18'(2 * dy);
            cells_left = 18'(1 + dx + dy);
        end else if (cells_left != 0) begin
            c = '{pos_x, pos_y, cells_left == 18'd1};
            expected_cells.insert(expected_cells.size(), c);
            // Positive error moves along x, otherwise along y.
            if (err_acc > 0) begin
                pos_x   = t_coord'(pos_x + (x_neg ? -1 : 1));
                err_acc = err_acc - $signed({1'b0, twice_dy});
            end else begin
                pos_y   = t_coord'(pos_y + (y_neg ? -1 : 1));
                err_acc = err_acc + $signed({1'b0, twice_dx});
            end
            cells_left = cells_left - 18'd1;
        end
    endtask

    // Drive one request, honoring the burst and gap pattern, and wait for it to be taken.
    task automatic send_request(input t_mode m, input t_coord xs, input t_coord ys,
                                input t_coord xe, input t_coord ye);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_x_start  <= xs;
        i_y_start  <= ys;
        i_x_end    <= xe;
        i_y_end    <= ye;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(m, xs, ys, xe, ye);
    endtask

    // Step request with random content in the unused coordinate fields.
    task automatic send_step();
        send_request(MODE_STEP, t_coord'($urandom), t_coord'($urandom),
                     t_coord'($urandom), t_coord'($urandom));
    endtask

    // Load a line and then issue a number of step requests.
    task automatic walk_line(input t_coord xs, input t_coord ys, input t_coord xe,
                             input t_coord ye, input int steps);
        send_request(MODE_LOAD, xs, ys, xe, ye);
        repeat (steps) send_step();
    endtask

    function automatic int line_cells(input t_coord xs, input t_coord ys,
                                      input t_coord xe, input t_coord ye);
        int dx;
        int dy;
        dx = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
        dy = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
        return 1 + dx + dy;
    endfunction

    // A coordinate within span of base, kept inside the signed range.
    function automatic t_coord near_coord(input t_coord base, input int span);
        int d;
        int v;
        d = int'($urandom_range(0, 2 * span)) - span;
        v = int'(base) + d;
        if (v > COORD_MAX || v < COORD_MIN)
            v = int'(base) - d;
        return t_coord'(v);
    endfunction

    // Compare every accepted cell with the oldest prediction.
    always @(posedge i_clk) begin : check_cells
        t_cell want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cells.size() == 0) begin
                report_mismatch($sformatf("unexpected cell (%0d, %0d) last %0b",
                                          o_cell_x, o_cell_y, o_last_cell));
            end else begin
                want = expected_cells.pop_front();
                if (o_cell_x !== want.x)
                    report_mismatch($sformatf("cell_x got %0d want %0d", o_cell_x, want.x));
                if (o_cell_y !== want.y)
                    report_mismatch($sformatf("cell_y got %0d want %0d", o_cell_y, want.y));
                if (o_last_cell !== want.is_last)
                    report_mismatch($sformatf("last_cell got %0b want %0b",
                                              o_last_cell, want.is_last));
            end
        end
    end

    // Steps before any load must give no cell.
    task automatic test_steps_without_walk();
        send_request(MODE_STEP, t_coord'(COORD_MIN), t_coord'(COORD_MAX),
                     t_coord'(COORD_MIN), t_coord'(COORD_MAX));
        send_request(MODE_STEP, t_coord'(COORD_MAX), t_coord'(COORD_MIN),
                     t_coord'(COORD_MAX), t_coord'(COORD_MIN));
        send_step();
    endtask

    // Lines at the coordinate limits, a single point, equal axes and wrap past the end.
    task automatic test_corner_lines();
        walk_line(16'sd0, 16'sd0, 16'sd0, 16'sd0, 2);
        walk_line(t_coord'(COORD_MAX - 1), t_coord'(COORD_MAX),
                  t_coord'(COORD_MAX), t_coord'(COORD_MAX), 3);
        walk_line(t_coord'(COORD_MIN), t_coord'(COORD_MIN + 1),
                  t_coord'(COORD_MIN), t_coord'(COORD_MIN), 2);
        walk_line(t_coord'(COORD_MIN + 1), 16'sd2, t_coord'(COORD_MIN), 16'sd0, 4);
    endtask

    // A new load drops the walk in progress.
    task automatic test_reload_during_walk();
        walk_line(t_coord'(COORD_MIN), t_coord'(COORD_MIN),
                  t_coord'(COORD_MAX), t_coord'(COORD_MAX), 3);
        walk_line(t_coord'(COORD_MAX), t_coord'(COORD_MIN),
                  t_coord'(COORD_MIN), t_coord'(COORD_MAX), 2);
        walk_line(16'sd5, -16'sd5, 16'sd3, -16'sd4, 4);
    endtask

    // Random lines: mostly short complete walks, some cut short, some huge, some noise.
    task automatic test_random_walks(input int quota, input int gap_limit,
                                     input int stall_level);
        int     done_items;
        int     kind;
        int     span;
        int     cells;
        int     steps;
        int     noise;
        t_coord xs;
        t_coord ys;
        t_coord xe;
        t_coord ye;
        gap_max    = gap_limit;
        stall_pct  = stall_level;
        done_items = 0;
        while (done_items < quota) begin
            kind = $urandom_range(0, 99);
            xs   = t_coord'($urandom);
            ys   = t_coord'($urandom);
            span = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 8);
            if (kind >= 95) begin
                // Noise: requests of either kind with arbitrary fields.
                noise = $urandom_range(1, 4);
                repeat (noise) begin
                    send_request(t_mode'($urandom_range(0, 1)), t_coord'($urandom),
                                 t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
                end
                done_items += noise;
            end else begin
                if (kind < 8) begin
                    xe = t_coord'($urandom);
                    ye = t_coord'($urandom);
                end else begin
                    xe = near_coord(xs, span);
                    ye = near_coord(ys, span);
                end
                cells = line_cells(xs, ys, xe, ye);
                if (kind < 8)
                    steps = $urandom_range(0, 8);
                else if (kind < 20)
                    steps = $urandom_range(0, cells - 1);
                else
                    steps = cells + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                walk_line(xs, ys, xe, ye, steps);
                done_items += 1 + ((steps < cells) ? steps : cells);
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_steps_without_walk();
        test_corner_lines();
        test_reload_during_walk();

        // Back to back, then sender gaps, receiver stalls, and both together.
        test_random_walks(475, 0, 0);
        test_random_walks(475, 6, 0);
        test_random_walks(475, 0, 50);
        test_random_walks(475, 8, 70);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        stall_pct  = 20;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
